### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/pig_pkg.sv
`timescale 1ns / 1ps

package pig_pkg;

    localparam int NUM_VARS   = 4;
    localparam int TABLE_BITS = 4;
    localparam int MAX_VARS   = (NUM_VARS < TABLE_BITS) ? NUM_VARS : TABLE_BITS;
    localparam int CUBE_W     = 4;
    localparam int TABLE_W    = 16;
    localparam int VC_W       = 3;
    localparam int DATA_W     = 2 * CUBE_W;

    typedef logic [1:0] digit_t;

    localparam digit_t DIG_DASH = 2'd0;
    localparam digit_t DIG_ZERO = 2'd1;
    localparam digit_t DIG_ONE  = 2'd2;

    typedef struct packed {
        logic [CUBE_W-1:0] mask;
        logic [CUBE_W-1:0] value;
    } cube_t;

    typedef struct packed {
        cube_t cube;
        logic  empty;
        logic  last;
    } result_t;

endpackage

### hw/rtl/prime_implicant_generator_unit.sv
// Flow: a table is taken only in idle; the scan then tests each of the 3^n cubes over
// the n variables (81 for four), and one flush state presents the final cube; an
// all-zero table goes straight to flush. No new table is taken until the flush is done,
// and the scan can hold while the result stream stalls; the cubes go through the single
// shared cube tester stepped by a base-3 digit counter. Reset: rst_n is asynchronous,
// active low; clears control state, var_count to 4.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module prime_implicant_generator_unit
    import pig_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [VC_W-1:0]    cfg_data,     // var_count
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TABLE_W-1:0] s_tdata,      // [15:0] truth_table
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,      // [3:0] cube_value, [7:4] cube_mask
    output logic               m_tuser,      // [0] empty_function
    output logic               m_tlast       // last_cube
);

    logic [VC_W-1:0]    var_count_reg;
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    logic               out_free;
    logic               push;
    result_t            push_res;
    logic [TABLE_W-1:0] fn;
    logic [TABLE_W-1:0] en;
    cube_t              cube;
    logic               prime;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    pig_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .var_count (var_count_reg),
        .out_free  (out_free),
        .push      (push),
        .push_res  (push_res),
        .fn        (fn),
        .en        (en),
        .cube      (cube),
        .prime     (prime)
    );

    pig_cube_test u_test (
        .fn    (fn),
        .en    (en),
        .cube  (cube),
        .prime (prime)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            var_count_reg <= VC_W'(4);
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                var_count_reg <= cfg_data;
            end
            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            m_res_reg <= push_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.cube.mask, m_res_reg.cube.value};
    assign m_tuser  = m_res_reg.empty;
    assign m_tlast  = m_res_reg.last;

    `ASSERT_IMPLIES(a_value_in_mask, clk, rst_n, m_tvalid, (m_tdata[3:0] & ~m_tdata[7:4]) == 4'd0)
    `ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == '0))
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLIES(a_push_has_room, clk, rst_n, push, out_free)

endmodule

### hw/rtl/pig_cube_test.sv
`timescale 1ns / 1ps

module pig_cube_test
    import pig_pkg::*;
(
    input  logic [TABLE_W-1:0] fn,
    input  logic [TABLE_W-1:0] en,
    input  cube_t              cube,
    output logic               prime
);

    function automatic logic is_implicant(
        input logic [TABLE_W-1:0] f,
        input logic [TABLE_W-1:0] e,
        input logic [CUBE_W-1:0]  val,
        input logic [CUBE_W-1:0]  msk
    );
        logic ok;
        ok = 1'b1;
        for (int m = 0; m < TABLE_W; m++) begin
            if (e[m] && ((CUBE_W'(m) & msk) == val) && !f[m]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        prime = is_implicant(fn, en, cube.value, cube.mask);
        for (int v = 0; v < CUBE_W; v++) begin
            if (cube.mask[v] &&
                is_implicant(fn, en, cube.value & ~(CUBE_W'(1) << v),
                             cube.mask & ~(CUBE_W'(1) << v))) begin
                prime = 1'b0;
            end
        end
    end

endmodule

### hw/rtl/pig_seq.sv
`timescale 1ns / 1ps

module pig_seq
    import pig_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TABLE_W-1:0] s_tdata,
    input  logic [VC_W-1:0]    var_count,
    input  logic               out_free,
    output logic               push,
    output result_t            push_res,
    output logic [TABLE_W-1:0] fn,
    output logic [TABLE_W-1:0] en,
    output cube_t              cube,
    input  logic               prime
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [TABLE_W-1:0] fn_reg, fn_next;
    logic [TABLE_W-1:0] en_reg, en_next;
    logic [VC_W-1:0]    nvar_reg, nvar_next;
    digit_t             digit_reg [CUBE_W];
    digit_t             digit_next [CUBE_W];
    digit_t             digit_inc [CUBE_W];
    cube_t              pend_reg, pend_next;
    logic               pend_empty_reg, pend_empty_next;
    logic               pend_valid_reg, pend_valid_next;

    logic [VC_W-1:0]    nvar_in;
    logic [TABLE_W-1:0] en_in;
    logic [TABLE_W-1:0] fn_in;
    logic               final_cube;
    logic               carry;
    logic               stall;

    always_comb
    begin
        if (var_count == '0) begin
            nvar_in = VC_W'(1);
        end else if (var_count > VC_W'(MAX_VARS)) begin
            nvar_in = VC_W'(MAX_VARS);
        end else begin
            nvar_in = var_count;
        end
    end

    always_comb
    begin
        unique case (nvar_in)
            3'd1:    en_in = 16'h0003;
            3'd2:    en_in = 16'h000F;
            3'd3:    en_in = 16'h00FF;
            default: en_in = 16'hFFFF;
        endcase
    end

    assign fn_in = s_tdata & en_in;

    always_comb
    begin
        final_cube = 1'b1;
        carry      = 1'b1;
        for (int v = 0; v < CUBE_W; v++) begin
            cube.mask[v]  = (digit_reg[v] != DIG_DASH);
            cube.value[v] = (digit_reg[v] == DIG_ONE);
            if ((VC_W'(v) < nvar_reg) && (digit_reg[v] != DIG_ONE)) begin
                final_cube = 1'b0;
            end
            if (carry) begin
                if (digit_reg[v] == DIG_ONE) begin
                    digit_inc[v] = DIG_DASH;
                end else begin
                    digit_inc[v] = digit_reg[v] + 2'd1;
                    carry        = 1'b0;
                end
            end else begin
                digit_inc[v] = digit_reg[v];
            end
        end
    end

    assign fn       = fn_reg;
    assign en       = en_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign stall    = prime && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        fn_next         = fn_reg;
        en_next         = en_reg;
        nvar_next       = nvar_reg;
        digit_next      = digit_reg;
        pend_next       = pend_reg;
        pend_empty_next = pend_empty_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_res        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    fn_next   = fn_in;
                    en_next   = en_in;
                    nvar_next = nvar_in;
                    for (int v = 0; v < CUBE_W; v++) begin
                        digit_next[v] = DIG_DASH;
                    end
                    if (fn_in == '0) begin
                        pend_next       = '0;
                        pend_empty_next = 1'b1;
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end else begin
                        pend_empty_next = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall) begin
                    if (prime) begin
                        if (pend_valid_reg) begin
                            push          = 1'b1;
                            push_res.cube = pend_reg;
                        end
                        pend_next       = cube;
                        pend_valid_next = 1'b1;
                    end
                    digit_next = digit_inc;
                    if (final_cube) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free) begin
                    push            = 1'b1;
                    push_res.cube   = pend_reg;
                    push_res.empty  = pend_empty_reg;
                    push_res.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg         <= fn_next;
        en_reg         <= en_next;
        nvar_reg       <= nvar_next;
        digit_reg      <= digit_next;
        pend_reg       <= pend_next;
        pend_empty_reg <= pend_empty_next;
    end

endmodule
